// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker of this block, msq_checker.
// Each macro assumes signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/msq_pkg.sv -----
// Types and constants of the masked oldest signal queue.
// Used by msq_slot_ram, msq_ctrl, the top level and its checker.
package msq_pkg;

    localparam int SIG_W      = 6;
    localparam int WORD_W     = 32;
    localparam int CODE_W     = 8;
    localparam int ACT_W      = 3;
    localparam int HOW_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 120;

    localparam logic [SIG_W-1:0] MAX_SIGNAL = 6'd32;

    localparam logic [ACT_W-1:0] ACT_ENQUEUE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ_SET   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DEQ_UNBLK = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MASK      = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PENDING   = 3'd4;

    localparam logic [HOW_W-1:0] HOW_BLOCK   = 2'd0;
    localparam logic [HOW_W-1:0] HOW_SETMASK = 2'd1;
    localparam logic [HOW_W-1:0] HOW_UNBLOCK = 2'd2;
    localparam logic [HOW_W-1:0] HOW_QUERY   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RSVD     = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [SIG_W-1:0]  sig;
        logic [WORD_W-1:0] value;
        logic [CODE_W-1:0] code;
        logic [HOW_W-1:0]  how;
        logic [WORD_W-1:0] set;
    } item_t;

    typedef struct packed {
        logic [SIG_W-1:0]  sig;
        logic [WORD_W-1:0] value;
        logic [CODE_W-1:0] code;
        logic [WORD_W-1:0] age;
    } slot_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SIG_W-1:0]    out_signal;
        logic [WORD_W-1:0]   out_value;
        logic [CODE_W-1:0]   out_code;
        logic [WORD_W-1:0]   old_mask;
        logic [WORD_W-1:0]   pending_set;
        logic                wake_raised;
    } result_t;

endpackage

// ----- rtl/core/msq_slot_ram.sv -----
// Slot table memory: one write port, one read port, registered read data.
// Depends on msq_pkg for the slot entry type.
module msq_slot_ram
    import msq_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  slot_t            wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output slot_t            rd_data
);

    slot_t mem [DEPTH];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/msq_ctrl.sv -----
// Sequencer of the signal queue: occupancy bits, blocked mask, stamp counter
// and the slot scan for dequeue and pending query. Depends on msq_pkg.
module msq_ctrl
    import msq_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  item_t            in_item,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_addr,
    output slot_t            wr_data,
    output logic [IDX_W-1:0] rd_addr,
    input  slot_t            rd_data,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_LAST   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [2:0]        state_reg, state_next;
    logic [DEPTH-1:0]  valid_reg, valid_next;
    logic [WORD_W-1:0] blocked_reg, blocked_next;
    logic [WORD_W-1:0] stamp_reg, stamp_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              cmp_pend_reg, cmp_pend_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [WORD_W-1:0] best_age_reg, best_age_next;
    logic [IDX_W-1:0]  pick_idx_reg, pick_idx_next;
    item_t             item_reg, item_next;
    logic [WORD_W-1:0] set_reg, set_next;
    result_t           res_reg, res_next;

    logic [IDX_W-1:0]  free_idx;
    logic              any_free;
    logic              is_deq;
    logic              hit_valid;
    logic [WORD_W-1:0] cmp_bit;
    logic [WORD_W-1:0] age_diff;
    logic              take;
    logic              pend_hit;

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        any_free = 1'b0;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_idx = IDX_W'(k);
                any_free = 1'b1;
            end
        end
    end

    assign is_deq    = (item_reg.action == ACT_DEQ_SET) || (item_reg.action == ACT_DEQ_UNBLK);
    assign hit_valid = cmp_pend_reg && valid_reg[cmp_idx_reg];
    assign cmp_bit   = 32'd1 << 5'(rd_data.sig - 6'd1);
    assign age_diff  = rd_data.age - best_age_reg;
    // ties keep the lower slot, since only a strictly older entry replaces the pick
    assign take      = is_deq && hit_valid && ((set_reg & cmp_bit) != '0)
                       && (!found_reg || age_diff[WORD_W-1]);
    assign pend_hit  = (item_reg.action == ACT_PENDING) && hit_valid
                       && ((blocked_reg & cmp_bit) != '0);

    assign rd_addr   = scan_idx_reg;
    assign wr_addr   = free_idx;
    assign wr_data   = '{sig: item_reg.sig, value: item_reg.value, code: item_reg.code,
                         age: stamp_reg + 32'd1};
    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);

    always_comb
    begin
        res = res_reg;
        if (is_deq && !found_reg)
        begin
            res.status = STATUS_NO_MATCH;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        blocked_next  = blocked_reg;
        stamp_next    = stamp_reg;
        scan_idx_next = scan_idx_reg;
        cmp_pend_next = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        found_next    = found_reg;
        best_age_next = best_age_reg;
        pick_idx_next = pick_idx_reg;
        item_next     = item_reg;
        set_next      = set_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next         = in_item;
                    res_next          = '0;
                    res_next.old_mask = blocked_reg;
                    found_next        = 1'b0;
                    scan_idx_next     = '0;
                    set_next          = (in_item.action == ACT_DEQ_SET) ? in_item.set
                                                                       : ~blocked_reg;
                    if ((in_item.action == ACT_DEQ_SET) || (in_item.action == ACT_DEQ_UNBLK)
                        || (in_item.action == ACT_PENDING))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESULT;
                priority if (item_reg.action == ACT_ENQUEUE)
                begin
                    // signals outside 1..32 are dropped silently
                    if ((item_reg.sig != '0) && (item_reg.sig <= MAX_SIGNAL))
                    begin
                        if (any_free)
                        begin
                            wr_en                = 1'b1;
                            valid_next[free_idx] = 1'b1;
                            stamp_next           = stamp_reg + 32'd1;
                            res_next.wake_raised = 1'b1;
                        end
                        else
                        begin
                            res_next.status = STATUS_FULL;
                        end
                    end
                end
                else if (item_reg.action == ACT_MASK)
                begin
                    unique case (item_reg.how)
                        HOW_BLOCK:   blocked_next = blocked_reg | item_reg.set;
                        HOW_SETMASK:
                        begin
                            blocked_next         = item_reg.set;
                            res_next.wake_raised = 1'b1;
                        end
                        HOW_UNBLOCK:
                        begin
                            blocked_next         = blocked_reg & ~item_reg.set;
                            res_next.wake_raised = 1'b1;
                        end
                        HOW_QUERY:   blocked_next = blocked_reg;
                    endcase
                end
                else
                begin
                    res_next = res_reg;
                end
            end
            ST_SCAN:
            begin
                cmp_pend_next = 1'b1;
                cmp_idx_next  = scan_idx_reg;
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_idx_reg == LAST_IDX)
                begin
                    scan_idx_next = '0;
                    state_next    = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                    // free the picked slot as the result leaves
                    if (is_deq && found_reg)
                    begin
                        valid_next[pick_idx_reg] = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // compare stage of the scan, one slot behind the read address
        if (take)
        begin
            found_next          = 1'b1;
            best_age_next       = rd_data.age;
            pick_idx_next       = cmp_idx_reg;
            res_next.out_signal = rd_data.sig;
            res_next.out_value  = rd_data.value;
            res_next.out_code   = rd_data.code;
        end
        if (pend_hit)
        begin
            res_next.pending_set = res_reg.pending_set | cmp_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            blocked_reg  <= '0;
            stamp_reg    <= '0;
            scan_idx_reg <= '0;
            cmp_pend_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            blocked_reg  <= blocked_next;
            stamp_reg    <= stamp_next;
            scan_idx_reg <= scan_idx_next;
            cmp_pend_reg <= cmp_pend_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        best_age_reg <= best_age_next;
        pick_idx_reg <= pick_idx_next;
        item_reg     <= item_next;
        set_reg      <= set_next;
        res_reg      <= res_next;
    end

endmodule

// ----- rtl/core/masked_oldest_signal_queue.sv -----
// Masked oldest signal queue: enqueue, masked dequeue of the oldest entry,
// blocked-mask update and pending query. Depends on msq_pkg, msq_ctrl, msq_slot_ram.
// Enqueue, mask update and unknown actions pass through the execute state; dequeue and
// pending query scan the slots one per cycle and finish in the last state, then the result state.
// One request in flight: a new one is taken only after the result has left for the output register.
// Reset (rst_n, async low) empties all slots and clears blocked mask and stamp.
module masked_oldest_signal_queue
    import msq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // signal_number[5:0], signal_value[37:6], signal_code[45:38],
    // mask_how[47:46], mask_set[79:48]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[2:0]
    input  logic [ACT_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[1:0], out_signal[7:2], out_value[39:8], out_code[47:40],
    // old_mask[79:48], pending_set[111:80], wake_raised[112], zero[119:113]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    item_t                 in_item;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    slot_t                 wr_data;
    logic [IDX_W-1:0]      rd_addr;
    slot_t                 rd_data;
    logic                  res_valid;
    logic                  res_ready;
    result_t               res;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign in_item = '{action: s_axis_tuser,
                       sig:    s_axis_tdata[5:0],
                       value:  s_axis_tdata[37:6],
                       code:   s_axis_tdata[45:38],
                       how:    s_axis_tdata[47:46],
                       set:    s_axis_tdata[79:48]};

    msq_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    msq_slot_ram #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register: load when empty or draining
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= {7'd0, res.wake_raised, res.pending_set, res.old_mask,
                             res.out_code, res.out_value, res.out_signal, res.status};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- rtl/core/msq_checker.sv -----
// Port-level checker for the masked oldest signal queue, bound to the top level.
// Depends on msq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module msq_checker
    import msq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [ACT_W-1:0]      s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata
);

    `MSQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `MSQ_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while one is in flight")
    `MSQ_ASSERT(a_status_code, (m_axis_tvalid |-> (m_axis_tdata[1:0] != STATUS_RSVD)), "reserved status code")
    `MSQ_ASSERT(a_signal_range, (m_axis_tvalid |-> (m_axis_tdata[7:2] <= MAX_SIGNAL)), "dequeued signal out of range")
    `MSQ_ASSERT(a_no_match_empty, ((m_axis_tvalid && (m_axis_tdata[1:0] == STATUS_NO_MATCH)) |-> ((m_axis_tdata[7:2] == 6'd0) && !m_axis_tdata[112])), "no-match result carries a signal or wake")

endmodule

bind masked_oldest_signal_queue msq_checker u_msq_checker (.*);
